// ===== rtl/htd_pkg.sv =====
// Shared types and constants for the hextile tile decoder.
`default_nettype none

package htd_pkg;

  // Default pixel width in bits
  localparam int unsigned PIXEL_BITS_DEF = 32;

  // Byte lane index inside one pixel (a pixel has at most four bytes)
  localparam int unsigned BIDX_W = 2;

  // Input word mode codes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_DATA  = 1'b1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_FILL  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  // One input word
  typedef struct packed {
    logic        mode;
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [15:0] rect_w;
    logic [15:0] rect_h;
    logic [7:0]  data_byte;
  } in_word_t;

  // One result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic [4:0]  out_w;
    logic [4:0]  out_h;
    logic [31:0] color;
    logic        rect_done;
  } out_word_t;

  // Result handed from the parser to the output stage
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/htd_parser.sv =====
// Hextile stream parser: tile walk, header decode, pixel assembly, result build.
`default_nettype none

module htd_parser #(
  parameter int unsigned PIXEL_BITS = htd_pkg::PIXEL_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire htd_pkg::in_word_t word_i,
  output htd_pkg::res_t          res_o
);
  import htd_pkg::*;

  localparam int unsigned PIX_BYTES = (PIXEL_BITS + 7) / 8;
  localparam int unsigned ACC_W     = PIX_BYTES * 8;

  // Header stage codes
  localparam logic [1:0] HDR_SUBENC = 2'd0;
  localparam logic [1:0] HDR_BG     = 2'd1;
  localparam logic [1:0] HDR_FG     = 2'd2;
  localparam logic [1:0] HDR_COUNT  = 2'd3;

  typedef enum logic [8:0] {
    PH_IDLE   = 9'b000000001,
    PH_SUBENC = 9'b000000010,
    PH_BG     = 9'b000000100,
    PH_FG     = 9'b000001000,
    PH_COUNT  = 9'b000010000,
    PH_RAW    = 9'b000100000,
    PH_SRCOL  = 9'b001000000,
    PH_SRXY   = 9'b010000000,
    PH_SRWH   = 9'b100000000
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [15:0]           origin_x_q, origin_x_d;
  logic [3:0]            tail_w_q, tail_w_d;
  logic [3:0]            tail_h_q, tail_h_d;
  logic [11:0]           last_col_q, last_col_d;
  logic [11:0]           last_row_q, last_row_d;
  logic [11:0]           tile_col_q, tile_col_d;
  logic [11:0]           tile_row_q, tile_row_d;
  logic [15:0]           tile_x_q, tile_x_d;
  logic [15:0]           tile_y_q, tile_y_d;
  logic [4:0]            flags_q, flags_d;
  logic [PIXEL_BITS-1:0] bg_q, bg_d;
  logic [PIXEL_BITS-1:0] fg_q, fg_d;
  logic [PIXEL_BITS-1:0] src_q, src_d;
  logic [ACC_W-1:0]      acc_q, acc_d;
  logic [BIDX_W-1:0]     bidx_q, bidx_d;
  logic [7:0]            count_q, count_d;
  logic [7:0]            pos_q, pos_d;
  logic [3:0]            raw_col_q, raw_col_d;
  logic [3:0]            raw_row_q, raw_row_d;

  logic [7:0]            b;
  logic [ACC_W-1:0]      acc_new;
  logic                  pix_done;
  logic [PIXEL_BITS-1:0] pix;
  logic                  last_col, last_row, last_tile;
  logic [4:0]            tile_w, tile_h;
  logic                  raw_last;
  logic [15:0]           start_wm1, start_hm1;

  logic                  hdr_run;
  logic [1:0]            hdr_stage;
  logic [4:0]            flg;
  logic [7:0]            cnt_v;
  logic [PIXEL_BITS-1:0] bg_v;
  logic                  do_next;
  logic [7:0]            cnt_dec;
  res_t                  res;

  assign b = word_i.data_byte;

  // Place the incoming byte into its lane of the pixel being assembled
  always_comb begin
    acc_new = acc_q;
    for (int i = 0; i < PIX_BYTES; i++) begin
      if (bidx_q == BIDX_W'(i)) begin
        acc_new[8*i +: 8] = b;
      end
    end
  end

  assign pix_done = (bidx_q == BIDX_W'(PIX_BYTES - 1));
  assign pix      = acc_new[PIXEL_BITS-1:0];

  // Geometry of the current tile
  assign last_col  = (tile_col_q == last_col_q);
  assign last_row  = (tile_row_q == last_row_q);
  assign last_tile = last_col & last_row;
  assign tile_w    = (last_col && tail_w_q != 4'd0) ? {1'b0, tail_w_q} : 5'd16;
  assign tile_h    = (last_row && tail_h_q != 4'd0) ? {1'b0, tail_h_q} : 5'd16;
  assign raw_last  = ({1'b0, raw_col_q} == tile_w - 5'd1) &&
                     ({1'b0, raw_row_q} == tile_h - 5'd1);
  assign start_wm1 = word_i.rect_w - 16'd1;
  assign start_hm1 = word_i.rect_h - 16'd1;
  assign cnt_dec   = count_q - 8'd1;

  // Decode one word: next state and result
  always_comb begin
    phase_d    = phase_q;
    origin_x_d = origin_x_q;
    tail_w_d   = tail_w_q;
    tail_h_d   = tail_h_q;
    last_col_d = last_col_q;
    last_row_d = last_row_q;
    tile_col_d = tile_col_q;
    tile_row_d = tile_row_q;
    tile_x_d   = tile_x_q;
    tile_y_d   = tile_y_q;
    flags_d    = flags_q;
    bg_d       = bg_q;
    fg_d       = fg_q;
    src_d      = src_q;
    acc_d      = acc_q;
    bidx_d     = bidx_q;
    count_d    = count_q;
    pos_d      = pos_q;
    raw_col_d  = raw_col_q;
    raw_row_d  = raw_row_q;
    res        = '0;
    hdr_run    = 1'b0;
    hdr_stage  = HDR_SUBENC;
    flg        = flags_q;
    cnt_v      = count_q;
    bg_v       = bg_q;
    do_next    = 1'b0;

    if (accept_i) begin
      if (word_i.mode == MODE_START) begin
        // Start a rectangle, dropping anything in progress
        origin_x_d = word_i.rect_x;
        tile_x_d   = word_i.rect_x;
        tile_y_d   = word_i.rect_y;
        tail_w_d   = word_i.rect_w[3:0];
        tail_h_d   = word_i.rect_h[3:0];
        last_col_d = start_wm1[15:4];
        last_row_d = start_hm1[15:4];
        tile_col_d = '0;
        tile_row_d = '0;
        flags_d    = '0;
        bg_d       = '0;
        fg_d       = '0;
        src_d      = '0;
        acc_d      = '0;
        bidx_d     = '0;
        count_d    = '0;
        pos_d      = '0;
        raw_col_d  = '0;
        raw_row_d  = '0;
        if (word_i.rect_w == 16'd0 || word_i.rect_h == 16'd0) begin
          res.valid          = 1'b1;
          res.word.kind      = KIND_EMPTY;
          res.word.out_x     = word_i.rect_x;
          res.word.out_y     = word_i.rect_y;
          res.word.rect_done = 1'b1;
          phase_d            = PH_IDLE;
        end else begin
          phase_d = PH_SUBENC;
        end
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
            // Drop stray data
          end
          PH_SUBENC: begin
            flg     = b[4:0];
            flags_d = b[4:0];
            count_d = '0;
            cnt_v   = '0;
            acc_d   = '0;
            bidx_d  = '0;
            if (b[0]) begin
              bg_d      = '0;
              fg_d      = '0;
              raw_col_d = '0;
              raw_row_d = '0;
              phase_d   = PH_RAW;
            end else begin
              hdr_run   = 1'b1;
              hdr_stage = HDR_SUBENC;
            end
          end
          PH_BG: begin
            acc_d  = acc_new;
            bidx_d = bidx_q + BIDX_W'(1);
            if (pix_done) begin
              acc_d     = '0;
              bidx_d    = '0;
              bg_d      = pix;
              bg_v      = pix;
              hdr_run   = 1'b1;
              hdr_stage = HDR_BG;
            end
          end
          PH_FG: begin
            acc_d  = acc_new;
            bidx_d = bidx_q + BIDX_W'(1);
            if (pix_done) begin
              acc_d     = '0;
              bidx_d    = '0;
              fg_d      = pix;
              hdr_run   = 1'b1;
              hdr_stage = HDR_FG;
            end
          end
          PH_COUNT: begin
            count_d   = b;
            cnt_v     = b;
            hdr_run   = 1'b1;
            hdr_stage = HDR_COUNT;
          end
          PH_RAW: begin
            acc_d  = acc_new;
            bidx_d = bidx_q + BIDX_W'(1);
            if (pix_done) begin
              acc_d              = '0;
              bidx_d             = '0;
              res.valid          = 1'b1;
              res.word.kind      = KIND_PIXEL;
              res.word.out_x     = tile_x_q + 16'(raw_col_q);
              res.word.out_y     = tile_y_q + 16'(raw_row_q);
              res.word.out_w     = 5'd1;
              res.word.out_h     = 5'd1;
              res.word.color     = 32'(pix);
              res.word.rect_done = raw_last & last_tile;
              if (raw_last) begin
                do_next = 1'b1;
              end else if ({1'b0, raw_col_q} == tile_w - 5'd1) begin
                raw_col_d = '0;
                raw_row_d = raw_row_q + 4'd1;
              end else begin
                raw_col_d = raw_col_q + 4'd1;
              end
            end
          end
          PH_SRCOL: begin
            acc_d  = acc_new;
            bidx_d = bidx_q + BIDX_W'(1);
            if (pix_done) begin
              acc_d   = '0;
              bidx_d  = '0;
              src_d   = pix;
              phase_d = PH_SRXY;
            end
          end
          PH_SRXY: begin
            pos_d   = b;
            phase_d = PH_SRWH;
          end
          PH_SRWH: begin
            count_d            = cnt_dec;
            res.valid          = 1'b1;
            res.word.kind      = KIND_FILL;
            res.word.out_x     = tile_x_q + 16'(pos_q[7:4]);
            res.word.out_y     = tile_y_q + 16'(pos_q[3:0]);
            res.word.out_w     = 5'(b[7:4]) + 5'd1;
            res.word.out_h     = 5'(b[3:0]) + 5'd1;
            res.word.color     = flags_q[4] ? 32'(src_q) : 32'(fg_q);
            res.word.rect_done = (cnt_dec == 8'd0) & last_tile;
            if (cnt_dec == 8'd0) begin
              do_next = 1'b1;
            end else begin
              phase_d = flags_q[4] ? PH_SRCOL : PH_SRXY;
            end
          end
          default: begin
          end
        endcase
      end
    end

    // Advance through the optional header fields, then emit the tile fill
    if (hdr_run) begin
      if (hdr_stage < HDR_BG && flg[1]) begin
        phase_d = PH_BG;
      end else if (hdr_stage < HDR_FG && flg[2]) begin
        phase_d = PH_FG;
      end else if (hdr_stage < HDR_COUNT && flg[3]) begin
        phase_d = PH_COUNT;
      end else begin
        if (flg[4]) begin
          fg_d = '0;
        end
        res.valid          = 1'b1;
        res.word.kind      = KIND_FILL;
        res.word.out_x     = tile_x_q;
        res.word.out_y     = tile_y_q;
        res.word.out_w     = tile_w;
        res.word.out_h     = tile_h;
        res.word.color     = 32'(bg_v);
        res.word.rect_done = (cnt_v == 8'd0) & last_tile;
        if (cnt_v == 8'd0) begin
          do_next = 1'b1;
        end else begin
          phase_d = flg[4] ? PH_SRCOL : PH_SRXY;
        end
      end
    end

    // Step to the next tile in row-major order, or finish
    if (do_next) begin
      if (!last_col) begin
        tile_col_d = tile_col_q + 12'd1;
        tile_x_d   = tile_x_q + 16'd16;
        phase_d    = PH_SUBENC;
      end else if (!last_row) begin
        tile_col_d = '0;
        tile_row_d = tile_row_q + 12'd1;
        tile_x_d   = origin_x_q;
        tile_y_d   = tile_y_q + 16'd16;
        phase_d    = PH_SUBENC;
      end else begin
        phase_d = PH_IDLE;
      end
    end
  end

  assign res_o = res;

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Geometry, colors and assembly registers; a start word sets them all
  always_ff @(posedge clk_i) begin
    origin_x_q <= origin_x_d;
    tail_w_q   <= tail_w_d;
    tail_h_q   <= tail_h_d;
    last_col_q <= last_col_d;
    last_row_q <= last_row_d;
    tile_col_q <= tile_col_d;
    tile_row_q <= tile_row_d;
    tile_x_q   <= tile_x_d;
    tile_y_q   <= tile_y_d;
    flags_q    <= flags_d;
    bg_q       <= bg_d;
    fg_q       <= fg_d;
    src_q      <= src_d;
    acc_q      <= acc_d;
    bidx_q     <= bidx_d;
    count_q    <= count_d;
    pos_q      <= pos_d;
    raw_col_q  <= raw_col_d;
    raw_row_q  <= raw_row_d;
  end

endmodule

`default_nettype wire

// ===== rtl/htd_out_stage.sv =====
// Result register between the parser and the output channel.
`default_nettype none

module htd_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire htd_pkg::res_t      res_i,
  output logic                   busy_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output htd_pkg::out_word_t      out_word_o
);
  import htd_pkg::*;

  logic      valid_q, valid_d;
  out_word_t word_q;

  // Hold while the receiver stalls a pending word
  assign busy_o  = valid_q & out_stall_i;
  assign valid_d = res_i.valid | busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load a new word only when one is produced
  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      word_q <= res_i.word;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

// ===== rtl/hextile_tile_decoder.sv =====
// Hextile rectangle decoder top level: parser plus output register.
//
//   channel  dir  payload               handshake
//   in       in   htd_pkg::in_word_t    in_valid_i / in_stall_o
//   out      out  htd_pkg::out_word_t   out_valid_o / out_stall_i
//
// One word is taken per cycle while the input does not stall; its result, if any, shows on the output
// in the cycle after acceptance, as the parser decodes combinationally ahead of the result register.
// Reset clears the parser phase to idle and empties the result register.
// The input stalls only while a result waits in the register and the sink stalls.
`default_nettype none

module hextile_tile_decoder #(
  parameter int unsigned PIXEL_BITS = htd_pkg::PIXEL_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire htd_pkg::in_word_t  in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output htd_pkg::out_word_t      out_word_o
);
  import htd_pkg::*;

  logic accept;
  logic busy;
  res_t res;

  // Take a word whenever the result register can absorb its result
  assign in_stall_o = busy;
  assign accept     = in_valid_i & ~busy;

  htd_parser #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .word_i  (in_word_i),
    .res_o   (res)
  );

  htd_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .busy_o     (busy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire

// ===== rtl/htd_checker.sv =====
// Port-level checks for the hextile decoder and their binding.
`default_nettype none

module htd_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire htd_pkg::in_word_t  in_word_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire htd_pkg::out_word_t out_word_o
);
  import htd_pkg::*;

  // A stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result changed");

  // Input backpressure only comes from a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // An empty rectangle start gives a marker in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_word_i.mode == MODE_START &&
    (in_word_i.rect_w == 16'd0 || in_word_i.rect_h == 16'd0)
    |=> out_valid_o && out_word_o.kind == KIND_EMPTY && out_word_o.rect_done)
    else $error("empty rectangle marker missing");

  // Raw pixels are one by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind == KIND_PIXEL
    |-> out_word_o.out_w == 5'd1 && out_word_o.out_h == 5'd1)
    else $error("raw pixel size is not one");

endmodule

bind hextile_tile_decoder htd_checker u_checker (.*);

`default_nettype wire

// ===== verif/hextile_tile_decoder_tb.sv =====
// Self-checking testbench for the hextile tile decoder: directed and random byte streams checked against a tile parser.
module hextile_tile_decoder_tb;
  import htd_pkg::*;

  localparam int unsigned PIX_BYTES    = (PIXEL_BITS_DEF + 7) / 8;
  localparam logic [63:0] PIX_MASK     = (64'd1 << PIXEL_BITS_DEF) - 64'd1;
  localparam int unsigned RANDOM_WORDS = 1100;
  localparam int unsigned ALL_TILES    = 32'h7fff_ffff;
  localparam int unsigned QUIET_CYCLES = 8;
  localparam int unsigned LIMIT_CYCLES = 600000;

  // Subencoding bit positions
  localparam int unsigned SE_RAW      = 0;
  localparam int unsigned SE_BG       = 1;
  localparam int unsigned SE_FG       = 2;
  localparam int unsigned SE_COUNT    = 3;
  localparam int unsigned SE_COLOURED = 4;

  typedef enum logic [3:0] {
    P_IDLE, P_SUBENC, P_BG, P_FG, P_COUNT, P_RAW, P_SRCOL, P_SRXY, P_SRWH
  } parse_phase_e;

  typedef enum logic [1:0] {
    SINK_FREE, SINK_RANDOM, SINK_SHORT, SINK_LONG
  } sink_mode_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_word_t  in_word_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_word_t out_word_o;

  hextile_tile_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // Tile parser state
  parse_phase_e ph;
  logic [15:0]  org_x, rect_wd, rect_ht, tpos_x, tpos_y;
  logic [11:0]  col_idx, row_idx;
  logic [4:0]   sub_flags;
  logic [31:0]  bg_px, fg_px, px_acc, sr_px;
  logic [1:0]   px_byte;
  logic [7:0]   sr_left, xy_byte, raw_idx;

  in_word_t    word_q[$];
  bit          hold_q[$];
  out_word_t   fill_q[$];
  int unsigned want_count, got_count, cycle_count;
  int unsigned gap_left, burst_left, errors;
  bit          offer, got_res;
  out_word_t   next_res, head_res;
  sink_mode_e  sink_mode;
  int unsigned sink_tick;

  always #6 clk_i = ~clk_i;

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------- parser model

  function automatic void clear_decoder();
    ph = P_IDLE;
    org_x = '0; rect_wd = '0; rect_ht = '0; tpos_x = '0; tpos_y = '0;
    col_idx = '0; row_idx = '0; sub_flags = '0;
    bg_px = '0; fg_px = '0; px_acc = '0; sr_px = '0; px_byte = '0;
    sr_left = '0; xy_byte = '0; raw_idx = '0;
  endfunction

  function automatic int unsigned tiles_wide();
    return (32'(rect_wd) + 15) >> 4;
  endfunction

  function automatic int unsigned tiles_high();
    return (32'(rect_ht) + 15) >> 4;
  endfunction

  // Edge tiles shrink to the leftover size
  function automatic int unsigned tile_w();
    if (col_idx + 1 == tiles_wide() && rect_wd[3:0] != 0) return rect_wd[3:0];
    return 16;
  endfunction

  function automatic int unsigned tile_h();
    if (row_idx + 1 == tiles_high() && rect_ht[3:0] != 0) return rect_ht[3:0];
    return 16;
  endfunction

  function automatic bit last_tile();
    return (col_idx + 1 == tiles_wide()) && (row_idx + 1 == tiles_high());
  endfunction

  // Step to the next tile in row-major order, or go idle after the last one
  function automatic void advance_tile();
    if (col_idx + 1 < tiles_wide()) begin
      col_idx = col_idx + 1;
      tpos_x  = tpos_x + 16;
      ph      = P_SUBENC;
    end else if (row_idx + 1 < tiles_high()) begin
      col_idx = '0;
      row_idx = row_idx + 1;
      tpos_x  = org_x;
      tpos_y  = tpos_y + 16;
      ph      = P_SUBENC;
    end else begin
      ph = P_IDLE;
    end
  endfunction

  // Collect little-endian pixel bytes; return 1 once the pixel is complete
  function automatic bit feed_byte(input logic [7:0] b);
    px_acc = px_acc | (32'(b) << (8 * px_byte));
    if (px_byte + 1 >= PIX_BYTES) begin
      px_acc  = px_acc & PIX_MASK[31:0];
      px_byte = '0;
      return 1'b1;
    end
    px_byte = px_byte + 1;
    return 1'b0;
  endfunction

  function automatic out_word_t make_result(input kind_e k, input logic [15:0] x, y,
                                            input logic [4:0] w, h, input logic [31:0] c,
                                            input logic d);
    out_word_t r;
    r.kind      = k;
    r.out_x     = x;
    r.out_y     = y;
    r.out_w     = w;
    r.out_h     = h;
    r.color     = c;
    r.rect_done = d;
    return r;
  endfunction

  // Move to the next header field, or emit the background fill once all are in
  function automatic bit header_step(input parse_phase_e stage, output out_word_t r);
    r = '0;
    if (stage < P_BG && sub_flags[SE_BG]) begin
      ph = P_BG;
      return 1'b0;
    end
    if (stage < P_FG && sub_flags[SE_FG]) begin
      ph = P_FG;
      return 1'b0;
    end
    if (stage < P_COUNT && sub_flags[SE_COUNT]) begin
      ph = P_COUNT;
      return 1'b0;
    end
    if (sub_flags[SE_COLOURED]) fg_px = '0;
    if (sr_left == 0) begin
      r = make_result(KIND_FILL, tpos_x, tpos_y, tile_w(), tile_h(), bg_px, last_tile());
      advance_tile();
      return 1'b1;
    end
    r  = make_result(KIND_FILL, tpos_x, tpos_y, tile_w(), tile_h(), bg_px, 1'b0);
    ph = sub_flags[SE_COLOURED] ? P_SRCOL : P_SRXY;
    return 1'b1;
  endfunction

  function automatic void decode_word(input in_word_t w, output bit has, output out_word_t r);
    logic [7:0]  b;
    int unsigned tw, th;
    b   = w.data_byte;
    has = 1'b0;
    r   = '0;
    if (w.mode == MODE_START) begin
      clear_decoder();
      org_x   = w.rect_x;
      tpos_x  = w.rect_x;
      tpos_y  = w.rect_y;
      rect_wd = w.rect_w;
      rect_ht = w.rect_h;
      if (rect_wd == 0 || rect_ht == 0) begin
        r   = make_result(KIND_EMPTY, org_x, tpos_y, '0, '0, '0, 1'b1);
        has = 1'b1;
        ph  = P_IDLE;
      end else begin
        ph = P_SUBENC;
      end
      return;
    end
    case (ph)
      P_SUBENC: begin
        sub_flags = b[4:0];
        sr_left   = '0;
        px_acc    = '0;
        px_byte   = '0;
        if (b[SE_RAW]) begin
          bg_px   = '0;
          fg_px   = '0;
          raw_idx = '0;
          ph      = P_RAW;
        end else begin
          has = header_step(P_SUBENC, r);
        end
      end
      P_BG: begin
        if (feed_byte(b)) begin
          bg_px  = px_acc;
          px_acc = '0;
          has    = header_step(P_BG, r);
        end
      end
      P_FG: begin
        if (feed_byte(b)) begin
          fg_px  = px_acc;
          px_acc = '0;
          has    = header_step(P_FG, r);
        end
      end
      P_COUNT: begin
        sr_left = b;
        has     = header_step(P_COUNT, r);
      end
      P_RAW: begin
        if (feed_byte(b)) begin
          tw = tile_w();
          th = tile_h();
          if (raw_idx + 1 >= tw * th) begin
            r = make_result(KIND_PIXEL, tpos_x + raw_idx % tw, tpos_y + raw_idx / tw,
                            5'd1, 5'd1, px_acc, last_tile());
            advance_tile();
          end else begin
            r = make_result(KIND_PIXEL, tpos_x + raw_idx % tw, tpos_y + raw_idx / tw,
                            5'd1, 5'd1, px_acc, 1'b0);
            raw_idx = raw_idx + 1;
          end
          px_acc = '0;
          has    = 1'b1;
        end
      end
      P_SRCOL: begin
        if (feed_byte(b)) begin
          sr_px  = px_acc;
          px_acc = '0;
          ph     = P_SRXY;
        end
      end
      P_SRXY: begin
        xy_byte = b;
        ph      = P_SRWH;
      end
      P_SRWH: begin
        sr_left = sr_left - 1;
        r = make_result(KIND_FILL, tpos_x + xy_byte[7:4], tpos_y + xy_byte[3:0],
                        b[7:4] + 1, b[3:0] + 1,
                        sub_flags[SE_COLOURED] ? sr_px : fg_px,
                        (sr_left == 0) ? last_tile() : 1'b0);
        has = 1'b1;
        if (sr_left == 0) advance_tile();
        else ph = sub_flags[SE_COLOURED] ? P_SRCOL : P_SRXY;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus build

  function automatic in_word_t rand_word();
    in_word_t w;
    w.mode      = $urandom_range(0, 1);
    w.rect_x    = $urandom_range(0, 65535);
    w.rect_y    = $urandom_range(0, 65535);
    w.rect_w    = $urandom_range(0, 65535);
    w.rect_h    = $urandom_range(0, 65535);
    w.data_byte = $urandom_range(0, 255);
    return w;
  endfunction

  function automatic void push_word(input in_word_t w, input bit hold);
    word_q.push_back(w);
    hold_q.push_back(hold);
  endfunction

  // Unused fields carry random values so every bit toggles
  function automatic void push_byte(input logic [7:0] b);
    in_word_t w;
    w           = rand_word();
    w.mode      = MODE_DATA;
    w.data_byte = b;
    push_word(w, 1'b0);
  endfunction

  function automatic void push_start(input logic [15:0] x, y, rw, rh, input bit hold);
    in_word_t w;
    w        = rand_word();
    w.mode   = MODE_START;
    w.rect_x = x;
    w.rect_y = y;
    w.rect_w = rw;
    w.rect_h = rh;
    push_word(w, hold);
  endfunction

  function automatic void push_pixel(input logic [31:0] p);
    for (int i = 0; i < PIX_BYTES; i++) push_byte(p[8*i +: 8]);
  endfunction

  // Emit a well-formed rectangle with random content; stop after max_tiles tiles
  function automatic void add_rect(input logic [15:0] rw, rh, input int unsigned max_tiles,
                                   input bit hold);
    int unsigned across, down, tw, th, cnt, made;
    logic [7:0]  flags;
    across = (32'(rw) + 15) / 16;
    down   = (32'(rh) + 15) / 16;
    made   = 0;
    push_start($urandom_range(0, 65535), $urandom_range(0, 65535), rw, rh, hold);
    for (int unsigned r = 0; r < down; r++) begin
      for (int unsigned c = 0; c < across; c++) begin
        if (made == max_tiles) return;
        made++;
        tw = (c + 1 == across && rw[3:0] != 0) ? rw[3:0] : 16;
        th = (r + 1 == down && rh[3:0] != 0) ? rh[3:0] : 16;
        flags = $urandom_range(0, 255);
        // keep raw tiles mostly small
        flags[SE_RAW] = (tw * th <= 64) ? ($urandom_range(0, 4) == 0)
                                        : ($urandom_range(0, 299) == 0);
        push_byte(flags);
        if (flags[SE_RAW]) begin
          repeat (tw * th * PIX_BYTES) push_byte($urandom_range(0, 255));
        end else begin
          if (flags[SE_BG]) push_pixel($urandom());
          if (flags[SE_FG]) push_pixel($urandom());
          cnt = 0;
          if (flags[SE_COUNT]) begin
            cnt = ($urandom_range(0, 49) == 0) ? $urandom_range(6, 255) : $urandom_range(0, 5);
            push_byte(cnt[7:0]);
          end
          repeat (cnt) begin
            if (flags[SE_COLOURED]) push_pixel($urandom());
            push_byte($urandom_range(0, 255));
            push_byte($urandom_range(0, 255));
          end
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------- driver

  // Accept on valid without stall; advance to the next word only when the current one is gone
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
      clear_decoder();
      want_count = 0;
      gap_left   = 0;
      burst_left = 1;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        decode_word(in_word_i, got_res, next_res);
        if (got_res) begin
          fill_q.push_back(next_res);
          want_count++;
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        offer = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (word_q.size() != 0 && !(hold_q[0] && want_count != got_count)) begin
          in_word_i <= word_q.pop_front();
          void'(hold_q.pop_front());
          offer = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        in_valid_i <= offer;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  // Check each accepted result word against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      got_count   <= 0;
      sink_tick   = 0;
      sink_mode   = SINK_FREE;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (fill_q.size() == 0) begin
          $error("result word with no expectation pending");
          errors++;
        end else begin
          head_res = fill_q.pop_front();
          got_count <= got_count + 1;
          if (out_word_o.kind != head_res.kind) begin
            $error("kind: expected %0d, actual %0d", head_res.kind, out_word_o.kind);
            errors++;
          end
          if (out_word_o.out_x != head_res.out_x) begin
            $error("out_x: expected %0d, actual %0d", head_res.out_x, out_word_o.out_x);
            errors++;
          end
          if (out_word_o.out_y != head_res.out_y) begin
            $error("out_y: expected %0d, actual %0d", head_res.out_y, out_word_o.out_y);
            errors++;
          end
          if (out_word_o.out_w != head_res.out_w) begin
            $error("out_w: expected %0d, actual %0d", head_res.out_w, out_word_o.out_w);
            errors++;
          end
          if (out_word_o.out_h != head_res.out_h) begin
            $error("out_h: expected %0d, actual %0d", head_res.out_h, out_word_o.out_h);
            errors++;
          end
          if (out_word_o.color != head_res.color) begin
            $error("color: expected %08h, actual %08h", head_res.color, out_word_o.color);
            errors++;
          end
          if (out_word_o.rect_done != head_res.rect_done) begin
            $error("rect_done: expected %0d, actual %0d", head_res.rect_done,
                   out_word_o.rect_done);
            errors++;
          end
        end
      end
      // Switch the stall pattern every so often
      if (sink_tick % 160 == 0) sink_mode = sink_mode_e'($urandom_range(0, 3));
      case (sink_mode)
        SINK_FREE:   out_stall_i <= 1'b0;
        SINK_RANDOM: out_stall_i <= ($urandom_range(0, 2) == 0);
        SINK_SHORT:  out_stall_i <= (sink_tick % 11) < 4;
        default:     out_stall_i <= (sink_tick % 37) < 15;
      endcase
      sink_tick++;
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int unsigned directed_len, pick, rect_num;
    errors      = 0;
    cycle_count = 0;

    // Directed: stray byte while idle, empty rectangles at the extremes
    push_byte(8'h5a);
    push_start(16'hffff, 16'h0000, 16'h0000, 16'hffff, 1'b0);
    push_start(16'h0000, 16'hffff, 16'hffff, 16'h0000, 1'b0);
    // 17x17 at the wrap point: full, narrow, short and 1x1 tiles
    push_start(16'hfff8, 16'hfff8, 16'd17, 16'd17, 1'b0);
    push_byte(8'he0);                 // upper bits only: plain background fill
    push_byte(8'h0e);                 // background, foreground, count
    push_pixel(32'hffff_ffff);
    push_pixel(32'h8000_0001);
    push_byte(8'h01);
    push_byte(8'hff);                 // subrect reaching past the tile
    push_byte(8'hff);
    push_byte(8'h18);                 // coloured with a count of zero
    push_byte(8'h00);
    push_byte(8'hf1);                 // raw wins over every other bit
    push_pixel(32'ha55a_3cc3);
    // Cut a rectangle short with a new start
    push_start(16'h0001, 16'h0002, 16'd16, 16'd16, 1'b0);
    push_byte(8'h02);
    push_byte(8'h77);
    push_start(16'h0000, 16'h0000, 16'd1, 16'd1, 1'b0);
    push_byte(8'h00);
    directed_len = word_q.size();

    // Random: hold off the first rectangle until everything has drained
    add_rect(16'd5, 16'd3, ALL_TILES, 1'b1);
    rect_num = 0;
    while (word_q.size() < directed_len + RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      rect_num++;
      if (pick < 4) begin
        repeat ($urandom_range(1, 3)) push_byte($urandom_range(0, 255));
      end else if (pick < 10) begin
        push_start($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(1, 40), $urandom_range(1, 40), rect_num % 50 == 0);
        repeat ($urandom_range(1, 12)) push_byte($urandom_range(0, 255));
      end else if (pick < 14) begin
        add_rect($urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(1, 3), rect_num % 50 == 0);
      end else if (pick < 18) begin
        if ($urandom_range(0, 1)) add_rect(16'd0, $urandom_range(0, 65535), 1, 1'b0);
        else add_rect($urandom_range(0, 65535), 16'd0, 1, 1'b0);
      end else if (pick < 60) begin
        add_rect($urandom_range(1, 20), $urandom_range(1, 20), ALL_TILES, rect_num % 50 == 0);
      end else begin
        add_rect($urandom_range(1, 48), $urandom_range(1, 48), ALL_TILES, rect_num % 50 == 0);
      end
    end

    // Drain, then leave a few quiet cycles for stray results
    do @(negedge clk_i);
    while (!rst_ni || word_q.size() != 0 || in_valid_i || want_count != got_count);
    repeat (QUIET_CYCLES) @(negedge clk_i);
    if (fill_q.size() != 0) begin
      $error("%0d expected results never arrived", fill_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
